[sv/slwd_pkg.sv]
// Shared types and constants for the stable load window detector.
// Holds the transaction structs, the configuration register map and reset values.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package slwd_pkg;

    // One input transaction: a current sample and its timestamp.
    typedef struct packed {
        logic [15:0] current_ma;
        logic [31:0] time_ms;
    } slwd_in_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] zero_run;
        logic        stable;
        logic        stable_start;
        logic        calibrate;
        logic [15:0] stable_value_ma;
    } slwd_out_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic        enable;
        logic [15:0] zero_threshold_ma;
        logic [31:0] variance_limit;
        logic [15:0] min_load_ma;
        logic [15:0] max_load_ma;
        logic [31:0] stable_time_ms;
        logic [31:0] recal_interval_ms;
    } slwd_cfg_t;

    // Per-sample control flags carried down the pipeline.
    typedef struct packed {
        logic proc;   // sample was taken while enabled
        logic zero;   // sample is below the zero threshold
        logic full;   // ring is full once this sample is pushed
    } slwd_flags_t;

    // Register map of the configuration port.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE         = 3'd0,
        REG_ZERO_THRESHOLD = 3'd1,
        REG_VARIANCE_LIMIT = 3'd2,
        REG_MIN_LOAD       = 3'd3,
        REG_MAX_LOAD       = 3'd4,
        REG_STABLE_TIME    = 3'd5,
        REG_RECAL_INTERVAL = 3'd6
    } slwd_reg_t;

    // Register values after reset.
    localparam slwd_cfg_t CFG_RESET = '{
        enable:            1'b1,
        zero_threshold_ma: 16'd50,
        variance_limit:    32'd10000,
        min_load_ma:       16'd500,
        max_load_ma:       16'd20000,
        stable_time_ms:    32'd30000,
        recal_interval_ms: 32'd1800000
    };

endpackage

`default_nettype wire

[sv/stable_load_window_detector_top.sv]
// Stable load window detector, top level: configuration registers and the three pipeline parts.
// A sample passes the ring, window and decision stages and then the result register.
// One sample per cycle unless stalled, set by the single-port ring and the running-sum update.
// Reset: control state, sums and period state clear and registers take their reset values;
// ring contents are left as they are and are masked until overwritten, with no clearing pass.
// Depends on slwd_pkg, slwd_ring, slwd_window and slwd_decide.
`default_nettype none

module stable_load_window_detector_top #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  slwd_pkg::slwd_in_t                  sample_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output slwd_pkg::slwd_out_t                 result_data,
    input  logic                                cfg_we,
    input  logic [slwd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slwd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import slwd_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PROD_W = 2 * SUM_W;

    slwd_cfg_t cfg_reg;

    logic                     rw_valid;
    logic                     rw_ready;
    slwd_flags_t              rw_flags;
    logic [31:0]              rw_time;
    logic [SAMPLE_BITS-1:0]   rw_new;
    logic [SAMPLE_BITS-1:0]   rw_old;
    logic [2*SAMPLE_BITS-1:0] rw_new_sq;
    logic [2*SAMPLE_BITS-1:0] rw_old_sq;

    logic                     wd_valid;
    logic                     wd_ready;
    slwd_flags_t              wd_flags;
    logic [31:0]              wd_time;
    logic [SUM_W-1:0]         wd_sum;
    logic [PROD_W-1:0]        wd_ss;
    logic [PROD_W-1:0]        wd_wq;
    logic [SAMPLE_BITS:0]     wd_mean;

    // Configuration register file; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (slwd_reg_t'(cfg_index))
                REG_ENABLE:         cfg_reg.enable            <= cfg_wdata[0];
                REG_ZERO_THRESHOLD: cfg_reg.zero_threshold_ma <= cfg_wdata[15:0];
                REG_VARIANCE_LIMIT: cfg_reg.variance_limit    <= cfg_wdata[31:0];
                REG_MIN_LOAD:       cfg_reg.min_load_ma       <= cfg_wdata[15:0];
                REG_MAX_LOAD:       cfg_reg.max_load_ma       <= cfg_wdata[15:0];
                REG_STABLE_TIME:    cfg_reg.stable_time_ms    <= cfg_wdata[31:0];
                REG_RECAL_INTERVAL: cfg_reg.recal_interval_ms <= cfg_wdata[31:0];
                default:            cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Ring memory and squares.
    slwd_ring #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .cfg          (cfg_reg),
        .dn_valid     (rw_valid),
        .dn_ready     (rw_ready),
        .dn_flags     (rw_flags),
        .dn_time      (rw_time),
        .dn_new       (rw_new),
        .dn_old       (rw_old),
        .dn_new_sq    (rw_new_sq),
        .dn_old_sq    (rw_old_sq)
    );

    // Running sums and products.
    slwd_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (rw_valid),
        .up_ready  (rw_ready),
        .up_flags  (rw_flags),
        .up_time   (rw_time),
        .up_new    (rw_new),
        .up_old    (rw_old),
        .up_new_sq (rw_new_sq),
        .up_old_sq (rw_old_sq),
        .dn_valid  (wd_valid),
        .dn_ready  (wd_ready),
        .dn_flags  (wd_flags),
        .dn_time   (wd_time),
        .dn_sum    (wd_sum),
        .dn_ss     (wd_ss),
        .dn_wq     (wd_wq),
        .dn_mean   (wd_mean)
    );

    // Stability tests, period tracking and result register.
    slwd_decide #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (wd_valid),
        .up_ready     (wd_ready),
        .up_flags     (wd_flags),
        .up_time      (wd_time),
        .up_sum       (wd_sum),
        .up_ss        (wd_ss),
        .up_wq        (wd_wq),
        .up_mean      (wd_mean),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

[sv/slwd_ring.sv]
// Sample ring of the stable load window detector: input stage, ring memory and squaring.
// Reads the sample that leaves the window and squares both the new and the old sample.
// Depends on slwd_pkg.
`default_nettype none

module slwd_ring #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  slwd_pkg::slwd_in_t         sample_data,
    input  slwd_pkg::slwd_cfg_t        cfg,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output slwd_pkg::slwd_flags_t      dn_flags,
    output logic [31:0]                dn_time,
    output logic [SAMPLE_BITS-1:0]     dn_new,
    output logic [SAMPLE_BITS-1:0]     dn_old,
    output logic [2*SAMPLE_BITS-1:0]   dn_new_sq,
    output logic [2*SAMPLE_BITS-1:0]   dn_old_sq
);
    import slwd_pkg::*;

    localparam int PTR_W    = $clog2(WINDOW);
    localparam int SQ_SMP_W = 2 * SAMPLE_BITS;
    localparam int THR_W    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW - 1);

    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];

    logic [PTR_W-1:0]       wp_reg;
    logic                   full_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    slwd_flags_t            flags1_reg;
    slwd_flags_t            flags2_reg;
    logic                   use_old1_reg;
    logic [SAMPLE_BITS-1:0] new1_reg;
    logic [SAMPLE_BITS-1:0] old1_reg;
    logic [SAMPLE_BITS-1:0] new2_reg;
    logic [SAMPLE_BITS-1:0] old2_reg;
    logic [SQ_SMP_W-1:0]    new_sq1_reg;
    logic [SQ_SMP_W-1:0]    new_sq2_reg;
    logic [SQ_SMP_W-1:0]    old_sq2_reg;
    logic [31:0]            time1_reg;
    logic [31:0]            time2_reg;

    logic                   smp_zero;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   load1;
    logic                   load2;
    logic                   accept;
    logic                   at_last;

    // Only the low SAMPLE_BITS bits of the current are used.
    assign smp      = SAMPLE_BITS'(sample_data.current_ma);
    assign smp_zero = THR_W'(smp) < THR_W'(cfg.zero_threshold_ma);
    assign at_last  = (wp_reg == LAST_POS);

    // Stage enables: a stage loads when it is empty or its content moves on.
    assign load2        = !v2_reg || dn_ready;
    assign load1        = !v1_reg || load2;
    assign accept       = sample_valid && load1;
    assign sample_stall = !load1;

    // Write pointer and fill flag advance on every enabled transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end
        else if (accept && cfg.enable)
        begin
            if (at_last)
            begin
                wp_reg   <= '0;
                full_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    // Ring memory: read-first, so the read returns the sample being replaced.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cfg.enable)
            begin
                ring_mem[wp_reg] <= smp;
            end
            old1_reg <= ring_mem[wp_reg];
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= sample_valid;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage 1 payload: flags, the new sample and its square.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags1_reg.proc <= cfg.enable;
            flags1_reg.zero <= smp_zero;
            flags1_reg.full <= full_reg || at_last;
            use_old1_reg    <= full_reg;
            new1_reg        <= smp;
            new_sq1_reg     <= SQ_SMP_W'(smp) * SQ_SMP_W'(smp);
            time1_reg       <= sample_data.time_ms;
        end
    end

    // Stage 2 payload: the leaving sample and its square, zero while the ring fills.
    always_ff @(posedge clk)
    begin
        if (load2 && v1_reg)
        begin
            flags2_reg  <= flags1_reg;
            new2_reg    <= new1_reg;
            new_sq2_reg <= new_sq1_reg;
            time2_reg   <= time1_reg;
            old2_reg    <= use_old1_reg ? old1_reg : '0;
            old_sq2_reg <= use_old1_reg ? SQ_SMP_W'(old1_reg) * SQ_SMP_W'(old1_reg) : '0;
        end
    end

    assign dn_valid  = v2_reg;
    assign dn_flags  = flags2_reg;
    assign dn_time   = time2_reg;
    assign dn_new    = new2_reg;
    assign dn_old    = old2_reg;
    assign dn_new_sq = new_sq2_reg;
    assign dn_old_sq = old_sq2_reg;

`ifndef NO_ASSERTIONS
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("ring fill flag dropped after the ring was full");

    a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg.enable) |=> $stable(wp_reg))
        else $error("write pointer moved on a disabled transaction");

    a_fill_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> (wp_reg == '0))
        else $error("ring became full without the pointer wrapping");
`endif

endmodule

`default_nettype wire

[sv/slwd_window.sv]
// Window statistics of the stable load window detector.
// Keeps the running sum and sum of squares and forms the products for the stability tests.
// Depends on slwd_pkg.
`default_nettype none

module slwd_window #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              up_valid,
    output logic                                              up_ready,
    input  slwd_pkg::slwd_flags_t                             up_flags,
    input  logic [31:0]                                       up_time,
    input  logic [SAMPLE_BITS-1:0]                            up_new,
    input  logic [SAMPLE_BITS-1:0]                            up_old,
    input  logic [2*SAMPLE_BITS-1:0]                          up_new_sq,
    input  logic [2*SAMPLE_BITS-1:0]                          up_old_sq,
    output logic                                              dn_valid,
    input  logic                                              dn_ready,
    output slwd_pkg::slwd_flags_t                             dn_flags,
    output logic [31:0]                                       dn_time,
    output logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]             dn_sum,
    output logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]         dn_ss,
    output logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]         dn_wq,
    output logic [SAMPLE_BITS:0]                              dn_mean
);
    import slwd_pkg::*;

    localparam int L      = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + L;
    localparam int SQ_W   = 2 * SAMPLE_BITS + L;
    localparam int PROD_W = 2 * SUM_W;
    localparam int M_W    = SUM_W + 1;
    localparam int MP_W   = SUM_W + M_W;
    localparam int MEAN_W = SAMPLE_BITS + 1;
    localparam int DIV_SH = SUM_W + L;
    // Reciprocal of WINDOW, rounded up: floor(S * DIV_MUL / 2^DIV_SH) equals S / WINDOW.
    localparam logic [63:0]    DIV_POW = 64'd1 << DIV_SH;
    localparam logic [63:0]    DIV_RND = (DIV_POW + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [M_W-1:0] DIV_MUL = DIV_RND[M_W-1:0];

    logic              v3_reg;
    logic              v4_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sq_reg;
    slwd_flags_t       flags3_reg;
    slwd_flags_t       flags4_reg;
    logic [31:0]       time3_reg;
    logic [31:0]       time4_reg;
    logic [SUM_W-1:0]  sum4_reg;
    logic [PROD_W-1:0] ss4_reg;
    logic [PROD_W-1:0] wq4_reg;
    logic [MP_W-1:0]   mp4_reg;

    logic [SUM_W-1:0]  sum_next;
    logic [SQ_W-1:0]   sq_next;
    logic              load3;
    logic              load4;

    assign load4    = !v4_reg || dn_ready;
    assign load3    = !v3_reg || load4;
    assign up_ready = load3;

    // Add the entering sample and drop the leaving one.
    assign sum_next = sum_reg + SUM_W'(up_new) - SUM_W'(up_old);
    assign sq_next  = sq_reg + SQ_W'(up_new_sq) - SQ_W'(up_old_sq);

    // Running sums and stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else
        begin
            if (load3)
            begin
                v3_reg <= up_valid;
            end
            if (load4)
            begin
                v4_reg <= v3_reg;
            end
            if (load3 && up_valid && up_flags.proc)
            begin
                sum_reg <= sum_next;
                sq_reg  <= sq_next;
            end
        end
    end

    // Stage 3 travels with the running sums it produced.
    always_ff @(posedge clk)
    begin
        if (load3 && up_valid)
        begin
            flags3_reg <= up_flags;
            time3_reg  <= up_time;
        end
    end

    // Stage 4: square of the sum, scaled sum of squares and the mean product.
    always_ff @(posedge clk)
    begin
        if (load4 && v3_reg)
        begin
            flags4_reg <= flags3_reg;
            time4_reg  <= time3_reg;
            sum4_reg   <= sum_reg;
            ss4_reg    <= PROD_W'(sum_reg) * PROD_W'(sum_reg);
            wq4_reg    <= PROD_W'(sq_reg) * PROD_W'(WINDOW);
            mp4_reg    <= MP_W'(sum_reg) * MP_W'(DIV_MUL);
        end
    end

    assign dn_valid = v4_reg;
    assign dn_flags = flags4_reg;
    assign dn_time  = time4_reg;
    assign dn_sum   = sum4_reg;
    assign dn_ss    = ss4_reg;
    assign dn_wq    = wq4_reg;
    assign dn_mean  = mp4_reg[MP_W-1 -: MEAN_W];

endmodule

`default_nettype wire

[sv/slwd_decide.sv]
// Stability decision of the stable load window detector.
// Compares the window statistics, tracks the stable period and drives the result register.
// Depends on slwd_pkg.
`default_nettype none

module slwd_decide #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              up_valid,
    output logic                                              up_ready,
    input  slwd_pkg::slwd_flags_t                             up_flags,
    input  logic [31:0]                                       up_time,
    input  logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]             up_sum,
    input  logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]         up_ss,
    input  logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]         up_wq,
    input  logic [SAMPLE_BITS:0]                              up_mean,
    input  slwd_pkg::slwd_cfg_t                               cfg,
    output logic                                              result_valid,
    input  logic                                              result_stall,
    output slwd_pkg::slwd_out_t                               result_data
);
    import slwd_pkg::*;

    localparam int L      = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + L;
    localparam int PROD_W = 2 * SUM_W;
    localparam int BND_W  = 32 + 2 * L;
    localparam int CMP_W  = (PROD_W > BND_W) ? PROD_W : BND_W;
    localparam int LW_W   = 16 + L;
    localparam int MCMP_W = (SUM_W > LW_W) ? SUM_W : LW_W;
    localparam int WSQ    = WINDOW * WINDOW;

    logic [BND_W-1:0] bound_reg;
    logic [LW_W-1:0]  minw_reg;
    logic [LW_W-1:0]  maxw_reg;
    logic             v5_reg;
    slwd_flags_t      flags5_reg;
    logic [31:0]      time5_reg;
    logic             ok5_reg;
    logic [15:0]      mean5_reg;
    logic             result_valid_reg;
    slwd_out_t        result_reg;
    logic [31:0]      zero_count_reg;
    logic             in_period_reg;
    logic [31:0]      period_start_reg;
    logic [15:0]      period_value_reg;
    logic [31:0]      last_cal_reg;

    logic [31:0]      zero_count_next;
    logic             in_period_next;
    logic [31:0]      period_start_next;
    logic [15:0]      period_value_next;
    logic [31:0]      last_cal_next;

    logic [PROD_W-1:0] spread;
    logic              var_ok;
    logic              min_ok;
    logic              max_ok;
    logic              load_out;
    logic              load5;
    logic              fire;
    logic              tested;
    logic              window_ok;
    logic              start;
    logic              calib;
    logic [31:0]       since_start;
    logic [31:0]       since_cal;

    assign load_out = !result_valid_reg || !result_stall;
    assign load5    = !v5_reg || load_out;
    assign up_ready = load5;
    assign fire     = v5_reg && load_out;

    // Scaled limits; configuration must only change while the pipeline is empty, which the block does not enforce.
    always_ff @(posedge clk)
    begin
        bound_reg <= BND_W'(cfg.variance_limit) * BND_W'(WSQ);
        minw_reg  <= LW_W'(cfg.min_load_ma) * LW_W'(WINDOW);
        maxw_reg  <= LW_W'(cfg.max_load_ma) * LW_W'(WINDOW);
    end

    // Exact integer tests on the window: W*Q - S*S against limit*W*W, S against load*W.
    assign spread = up_wq - up_ss;
    assign var_ok = CMP_W'(spread) < CMP_W'(bound_reg);
    assign min_ok = MCMP_W'(up_sum) >= MCMP_W'(minw_reg);
    assign max_ok = MCMP_W'(up_sum) <= MCMP_W'(maxw_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (load5)
        begin
            v5_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load5 && up_valid)
        begin
            flags5_reg <= up_flags;
            time5_reg  <= up_time;
            ok5_reg    <= var_ok && min_ok && max_ok;
            mean5_reg  <= 16'(up_mean);
        end
    end

    // Zero run and stable period bookkeeping for the transaction leaving stage 5.
    always_comb
    begin
        tested            = flags5_reg.proc && !flags5_reg.zero && flags5_reg.full;
        window_ok         = tested && ok5_reg;
        start             = window_ok && !in_period_reg;
        calib             = 1'b0;
        since_start       = time5_reg - period_start_reg;
        since_cal         = time5_reg - last_cal_reg;
        zero_count_next   = zero_count_reg;
        in_period_next    = in_period_reg;
        period_start_next = period_start_reg;
        period_value_next = period_value_reg;
        last_cal_next     = last_cal_reg;

        if (flags5_reg.proc)
        begin
            if (flags5_reg.zero)
            begin
                if (zero_count_reg != '1)
                begin
                    zero_count_next = zero_count_reg + 32'd1;
                end
            end
            else
            begin
                zero_count_next = '0;
            end
        end

        if (start)
        begin
            period_start_next = time5_reg;
            period_value_next = mean5_reg;
            in_period_next    = 1'b1;
        end
        else if (window_ok)
        begin
            // A long enough period ends, with a request if the interval has passed.
            if (since_start > cfg.stable_time_ms)
            begin
                if (since_cal > cfg.recal_interval_ms)
                begin
                    calib         = 1'b1;
                    last_cal_next = time5_reg;
                end
                in_period_next = 1'b0;
            end
        end
        else if (tested)
        begin
            in_period_next = 1'b0;
        end
    end

    // Period state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            zero_count_reg   <= '0;
            in_period_reg    <= 1'b0;
            period_start_reg <= '0;
            period_value_reg <= '0;
            last_cal_reg     <= '0;
        end
        else
        begin
            if (load_out)
            begin
                result_valid_reg <= v5_reg;
            end
            if (fire)
            begin
                zero_count_reg   <= zero_count_next;
                in_period_reg    <= in_period_next;
                period_start_reg <= period_start_next;
                period_value_reg <= period_value_next;
                last_cal_reg     <= last_cal_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg.zero_run        <= zero_count_next;
            result_reg.stable          <= window_ok;
            result_reg.stable_start    <= start;
            result_reg.calibrate       <= calib;
            result_reg.stable_value_ma <= period_value_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef NO_ASSERTIONS
    a_cal_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.calibrate) |-> !in_period_reg)
        else $error("calibrate issued while the stable period stays open");

    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.stable_start) |-> in_period_reg)
        else $error("stable start did not open a period");

    a_zero_unstable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.zero_run != '0)) |-> !result_reg.stable)
        else $error("window reported stable during a zero run");
`endif

endmodule

`default_nettype wire
